FILE: sv/layp_pkg.sv
// ============================================================================
// layp_pkg
// Shared types, constants and helpers of the landing altitude and yaw PD core.
// ============================================================================
package layp_pkg;

    localparam int ACC_W      = 88;
    localparam int MPL_W      = 42;
    localparam int NUM_W      = 42;
    localparam int SQ_W       = 50;
    localparam int DEN_W      = 29;
    localparam int CNT_W      = 6;
    localparam int DIV_STEPS  = NUM_W;
    localparam int SQRT_STEPS = SQ_W / 2;

    typedef logic signed [ACC_W-1:0] acc_t;

    localparam logic [23:0] RST_KP_ALT   = 24'd98304;
    localparam logic [23:0] RST_KD_ALT   = 24'd19661;
    localparam logic [23:0] RST_KP_HDG   = 24'd98304;
    localparam logic [23:0] RST_KD_HDG   = 24'd19661;
    localparam logic [23:0] RST_DIST_LIM = 24'd98304;
    localparam logic [23:0] RST_VEL_LIM  = 24'd19661;
    localparam logic [23:0] RST_CRUISE   = 24'd117965;
    localparam logic [9:0]  RST_TPS      = 10'd20;

    localparam acc_t SAT_HI = acc_t'(32'sh7FFF_FFFF);
    localparam acc_t SAT_LO = acc_t'(32'sh8000_0000);

    typedef enum logic [1:0] {
        OP_MAC,
        OP_DIV,
        OP_SQRT
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
        logic    neg;
    } alu_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

    typedef enum logic [2:0] {
        CFG_KP_ALT   = 3'd0,
        CFG_KD_ALT   = 3'd1,
        CFG_KP_HDG   = 3'd2,
        CFG_KD_HDG   = 3'd3,
        CFG_DIST_LIM = 3'd4,
        CFG_VEL_LIM  = 3'd5,
        CFG_CRUISE   = 3'd6,
        CFG_TPS      = 3'd7
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MX,
        ST_MY,
        ST_GR,
        ST_DX,
        ST_DY,
        ST_VX,
        ST_VY,
        ST_DL,
        ST_VL,
        ST_T1,
        ST_T2,
        ST_C1,
        ST_C2,
        ST_P1,
        ST_P2,
        ST_SQ,
        ST_DV,
        ST_SM,
        ST_OUT
    } state_t;

    // Floor of v / 2^16, saturated to a signed 32-bit value.
    function automatic logic [31:0] sat_q16(input logic [ACC_W-1:0] v);
        acc_t sh;
        begin
            sh = $signed(v) >>> 16;
            if (sh > SAT_HI) begin
                sat_q16 = 32'h7FFF_FFFF;
            end
            else if (sh < SAT_LO) begin
                sat_q16 = 32'h8000_0000;
            end
            else begin
                sat_q16 = sh[31:0];
            end
        end
    endfunction

endpackage

FILE: sv/layp_alu.sv
// ============================================================================
// layp_alu
// Iterative arithmetic unit: shift-add multiply-accumulate, restoring divide
// and restoring square root, all on one shared adder, one bit per cycle.
// ============================================================================
module layp_alu (
    input  logic                              clk,
    input  logic                              rst_n,
    input  layp_pkg::alu_cmd_t                cmd,
    input  logic [layp_pkg::ACC_W-1:0]        acc_in,
    input  logic [layp_pkg::ACC_W-1:0]        opa,
    input  logic [layp_pkg::MPL_W-1:0]        opb,
    output layp_pkg::alu_stat_t               stat,
    output logic [layp_pkg::ACC_W-1:0]        res
);
    import layp_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    alu_op_t          op_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] x_reg;
    logic [MPL_W-1:0] y_reg;
    logic [DEN_W-1:0] den_reg;

    logic [ACC_W-1:0] add_a;
    logic [ACC_W-1:0] add_b;
    logic             add_cin;
    logic [ACC_W-1:0] sum;
    logic [ACC_W-1:0] part_div;
    logic [ACC_W-1:0] part_sq;
    logic             fits;
    logic             step_last;

    assign part_div = {acc_reg[ACC_W-2:0], x_reg[NUM_W-1]};
    assign part_sq  = {acc_reg[ACC_W-3:0], x_reg[SQ_W-1:SQ_W-2]};

    always_comb
    begin
        case (op_reg)
            OP_MAC:
            begin
                add_a   = acc_reg;
                add_b   = neg_reg ? ~x_reg : x_reg;
                add_cin = neg_reg;
            end
            OP_DIV:
            begin
                add_a   = part_div;
                add_b   = ~ACC_W'(den_reg);
                add_cin = 1'b1;
            end
            OP_SQRT:
            begin
                add_a   = part_sq;
                add_b   = ~ACC_W'({y_reg, 2'b01});
                add_cin = 1'b1;
            end
            default:
            begin
                add_a   = '0;
                add_b   = '0;
                add_cin = 1'b0;
            end
        endcase
    end

    assign sum       = add_a + add_b + ACC_W'(add_cin);
    assign fits      = ~sum[ACC_W-1];
    assign step_last = (op_reg == OP_MAC) ? (y_reg == '0) : (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MAC;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= cmd.op;
                neg_reg  <= cmd.neg;
                cnt_reg  <= (cmd.op == OP_DIV) ? CNT_W'(DIV_STEPS) : CNT_W'(SQRT_STEPS);
            end
            else if (busy_reg && step_last)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_reg <= (cmd.op == OP_MAC) ? acc_in : '0;
            x_reg   <= opa;
            y_reg   <= (cmd.op == OP_MAC) ? opb : '0;
            den_reg <= opb[DEN_W-1:0];
        end
        else if (busy_reg && !step_last)
        begin
            case (op_reg)
                OP_MAC:
                begin
                    if (y_reg[0])
                    begin
                        acc_reg <= sum;
                    end
                    x_reg <= x_reg << 1;
                    y_reg <= y_reg >> 1;
                end
                OP_DIV:
                begin
                    acc_reg <= fits ? sum : part_div;
                    x_reg   <= x_reg << 1;
                    y_reg   <= {y_reg[MPL_W-2:0], fits};
                end
                OP_SQRT:
                begin
                    acc_reg <= fits ? sum : part_sq;
                    x_reg   <= x_reg << 2;
                    y_reg   <= {y_reg[MPL_W-2:0], fits};
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign res       = (op_reg == OP_MAC) ? acc_reg : ACC_W'(y_reg);

endmodule

FILE: sv/landing_altitude_yaw_pd_core.sv
// ============================================================================
// landing_altitude_yaw_pd_core
// Per control tick: target motion estimate, landing decision, altitude PD
// with landing scale, and yaw PD, computed on one shared iterative unit.
// ============================================================================
// One tick takes longer when landing than when climbing. The shared arithmetic
// unit handles one multiplier, quotient or root bit per cycle through a chain
// of multiply-accumulate, square root and divide steps. The input side is ready
// only while no tick is in work; a finished result sits in the output register
// until it is taken, and the next tick may be accepted meanwhile.
module landing_altitude_yaw_pd_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // target_x, target_y, target_heading, pos_x, pos_y, pos_z, heading,
    // vel_x, vel_y, vel_z, heading_rate; 32 bits each from the lowest bit up
    input  logic [351:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // climb_cmd [31:0], turn_cmd [63:32], landing [64], zero fill [71:65]
    output logic [71:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data
);
    import layp_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   issued_reg;
    logic   out_valid_reg;
    logic   out_load;
    logic   in_fire;

    logic [23:0] kp_alt_reg;
    logic [23:0] kd_alt_reg;
    logic [23:0] kp_hdg_reg;
    logic [23:0] kd_hdg_reg;
    logic [23:0] dl_reg;
    logic [23:0] vl_reg;
    logic [23:0] cruise_reg;
    logic [9:0]  tps_reg;

    logic signed [31:0] prev_x_reg;
    logic signed [31:0] prev_y_reg;
    logic signed [31:0] prev_h_reg;

    logic signed [31:0] tx_reg;
    logic signed [31:0] ty_reg;
    logic signed [31:0] th_reg;
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic signed [31:0] pz_reg;
    logic signed [31:0] hd_reg;
    logic signed [31:0] vx_reg;
    logic signed [31:0] vy_reg;
    logic signed [31:0] vz_reg;
    logic signed [31:0] hr_reg;

    logic signed [43:0] nmx_reg;
    logic signed [43:0] nmy_reg;
    logic signed [43:0] nyd_reg;
    logic [ACC_W-1:0]   part_reg;
    logic [SQ_W-1:0]    dsq_reg;
    logic [SQ_W-1:0]    vsq_reg;
    logic               d_ok_reg;
    logic               v_ok_reg;
    logic [31:0]        turn_reg;
    logic [31:0]        climb_reg;
    logic signed [41:0] pd_reg;
    logic [24:0]        root_reg;
    logic [NUM_W-1:0]   s_reg;
    logic [71:0]        out_data_reg;
    logic               land_reg;

    logic signed [32:0] diff_x;
    logic signed [32:0] diff_y;
    logic signed [32:0] diff_h;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] eh;
    logic signed [33:0] ealt;
    logic [NUM_W-1:0]   num;
    logic [DEN_W-1:0]   den;

    alu_cmd_t         alu_cmd;
    alu_stat_t        alu_stat;
    logic [ACC_W-1:0] alu_acc_in;
    logic [ACC_W-1:0] alu_opa;
    logic [MPL_W-1:0] alu_opb;
    logic [ACC_W-1:0] alu_res;

    function automatic logic [24:0] clamp_mag(input logic signed [43:0] v);
        logic [43:0] m;
        begin
            m = v[43] ? (~v + 44'd1) : v;
            if (m > 44'h100_0000)
            begin
                clamp_mag = 25'h100_0000;
            end
            else
            begin
                clamp_mag = m[24:0];
            end
        end
    endfunction

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_load      = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign land_reg      = d_ok_reg && v_ok_reg;

    assign diff_x = 33'(tx_reg) - 33'(prev_x_reg);
    assign diff_y = 33'(ty_reg) - 33'(prev_y_reg);
    assign diff_h = 33'(th_reg) - 33'(prev_h_reg);
    assign dx     = 33'(tx_reg) - 33'(px_reg);
    assign dy     = 33'(ty_reg) - 33'(py_reg);
    assign eh     = 33'(th_reg) - 33'(hd_reg);
    assign ealt   = $signed({10'd0, cruise_reg}) - 34'(pz_reg);
    assign num    = {({2'b00, dl_reg} + {1'b0, dl_reg, 1'b0}), 16'd0};
    assign den    = {1'b0, root_reg, 3'b000} + {3'b000, root_reg, 1'b0};

    layp_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (alu_cmd),
        .acc_in (alu_acc_in),
        .opa    (alu_opa),
        .opb    (alu_opb),
        .stat   (alu_stat),
        .res    (alu_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (alu_cmd.start)
            begin
                issued_reg <= 1'b1;
            end
            else if (alu_stat.done)
            begin
                issued_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        alu_cmd.op    = OP_MAC;
        alu_cmd.neg   = 1'b0;
        alu_acc_in    = '0;
        alu_opa       = '0;
        alu_opb       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_MX;
                end
            end
            ST_MX:
            begin
                alu_cmd.neg = 1'b1;
                alu_acc_in  = acc_t'(vx_reg);
                alu_opa     = acc_t'(diff_x);
                alu_opb     = MPL_W'(tps_reg);
                if (alu_stat.done) state_next = ST_MY;
            end
            ST_MY:
            begin
                alu_cmd.neg = 1'b1;
                alu_acc_in  = acc_t'(vy_reg);
                alu_opa     = acc_t'(diff_y);
                alu_opb     = MPL_W'(tps_reg);
                if (alu_stat.done) state_next = ST_GR;
            end
            ST_GR:
            begin
                alu_cmd.neg = 1'b1;
                alu_acc_in  = acc_t'(hr_reg);
                alu_opa     = acc_t'(diff_h);
                alu_opb     = MPL_W'(tps_reg);
                if (alu_stat.done) state_next = ST_DX;
            end
            ST_DX:
            begin
                alu_opa = ACC_W'(clamp_mag(44'(dx)));
                alu_opb = MPL_W'(clamp_mag(44'(dx)));
                if (alu_stat.done) state_next = ST_DY;
            end
            ST_DY:
            begin
                alu_acc_in = part_reg;
                alu_opa    = ACC_W'(clamp_mag(44'(dy)));
                alu_opb    = MPL_W'(clamp_mag(44'(dy)));
                if (alu_stat.done) state_next = ST_VX;
            end
            ST_VX:
            begin
                alu_opa = ACC_W'(clamp_mag(nmx_reg));
                alu_opb = MPL_W'(clamp_mag(nmx_reg));
                if (alu_stat.done) state_next = ST_VY;
            end
            ST_VY:
            begin
                alu_acc_in = part_reg;
                alu_opa    = ACC_W'(clamp_mag(nmy_reg));
                alu_opb    = MPL_W'(clamp_mag(nmy_reg));
                if (alu_stat.done) state_next = ST_DL;
            end
            ST_DL:
            begin
                alu_opa = ACC_W'(dl_reg);
                alu_opb = MPL_W'(dl_reg);
                if (alu_stat.done) state_next = ST_VL;
            end
            ST_VL:
            begin
                alu_opa = ACC_W'(vl_reg);
                alu_opb = MPL_W'(vl_reg);
                if (alu_stat.done) state_next = ST_T1;
            end
            ST_T1:
            begin
                alu_opa = acc_t'(eh);
                alu_opb = MPL_W'(kp_hdg_reg);
                if (alu_stat.done) state_next = ST_T2;
            end
            ST_T2:
            begin
                alu_cmd.neg = 1'b1;
                alu_acc_in  = part_reg;
                alu_opa     = acc_t'(nyd_reg);
                alu_opb     = MPL_W'(kd_hdg_reg);
                if (alu_stat.done) state_next = land_reg ? ST_P1 : ST_C1;
            end
            ST_C1:
            begin
                alu_opa = acc_t'(ealt);
                alu_opb = MPL_W'(kp_alt_reg);
                if (alu_stat.done) state_next = ST_C2;
            end
            ST_C2:
            begin
                alu_cmd.neg = 1'b1;
                alu_acc_in  = part_reg;
                alu_opa     = acc_t'(vz_reg);
                alu_opb     = MPL_W'(kd_alt_reg);
                if (alu_stat.done) state_next = ST_OUT;
            end
            ST_P1:
            begin
                alu_cmd.neg = 1'b1;
                alu_opa     = acc_t'(pz_reg);
                alu_opb     = MPL_W'(kp_alt_reg);
                if (alu_stat.done) state_next = ST_P2;
            end
            ST_P2:
            begin
                alu_cmd.neg = 1'b1;
                alu_acc_in  = part_reg;
                alu_opa     = acc_t'(vz_reg);
                alu_opb     = MPL_W'(kd_alt_reg);
                if (alu_stat.done) state_next = ST_SQ;
            end
            ST_SQ:
            begin
                alu_cmd.op = OP_SQRT;
                alu_opa    = ACC_W'(dsq_reg);
                if (alu_stat.done)
                begin
                    state_next = (alu_res == '0) ? ST_OUT : ST_DV;
                end
            end
            ST_DV:
            begin
                alu_cmd.op = OP_DIV;
                alu_opa    = ACC_W'(num);
                alu_opb    = MPL_W'(den);
                if (alu_stat.done) state_next = ST_SM;
            end
            ST_SM:
            begin
                alu_opa = acc_t'(pd_reg);
                alu_opb = s_reg;
                if (alu_stat.done) state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        alu_cmd.start = (state_reg != ST_IDLE) && (state_reg != ST_OUT) && !issued_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_alt_reg    <= RST_KP_ALT;
            kd_alt_reg    <= RST_KD_ALT;
            kp_hdg_reg    <= RST_KP_HDG;
            kd_hdg_reg    <= RST_KD_HDG;
            dl_reg        <= RST_DIST_LIM;
            vl_reg        <= RST_VEL_LIM;
            cruise_reg    <= RST_CRUISE;
            tps_reg       <= RST_TPS;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_h_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_KP_ALT:   kp_alt_reg <= cfg_data;
                    CFG_KD_ALT:   kd_alt_reg <= cfg_data;
                    CFG_KP_HDG:   kp_hdg_reg <= cfg_data;
                    CFG_KD_HDG:   kd_hdg_reg <= cfg_data;
                    CFG_DIST_LIM: dl_reg     <= cfg_data;
                    CFG_VEL_LIM:  vl_reg     <= cfg_data;
                    CFG_CRUISE:   cruise_reg <= cfg_data;
                    CFG_TPS:      tps_reg    <= cfg_data[9:0];
                    default:      tps_reg    <= tps_reg;
                endcase
            end
            if (out_load)
            begin
                prev_x_reg    <= tx_reg;
                prev_y_reg    <= ty_reg;
                prev_h_reg    <= th_reg;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            tx_reg <= s_axis_tdata[31:0];
            ty_reg <= s_axis_tdata[63:32];
            th_reg <= s_axis_tdata[95:64];
            px_reg <= s_axis_tdata[127:96];
            py_reg <= s_axis_tdata[159:128];
            pz_reg <= s_axis_tdata[191:160];
            hd_reg <= s_axis_tdata[223:192];
            vx_reg <= s_axis_tdata[255:224];
            vy_reg <= s_axis_tdata[287:256];
            vz_reg <= s_axis_tdata[319:288];
            hr_reg <= s_axis_tdata[351:320];
        end
        if (out_load)
        begin
            out_data_reg <= {7'd0, land_reg, turn_reg, climb_reg};
        end
        if (alu_stat.done)
        begin
            part_reg <= alu_res;
            case (state_reg)
                ST_MX: nmx_reg  <= alu_res[43:0];
                ST_MY: nmy_reg  <= alu_res[43:0];
                ST_GR: nyd_reg  <= alu_res[43:0];
                ST_DY: dsq_reg  <= alu_res[SQ_W-1:0];
                ST_VY: vsq_reg  <= alu_res[SQ_W-1:0];
                ST_DL: d_ok_reg <= ACC_W'(dsq_reg) < alu_res;
                ST_VL: v_ok_reg <= ACC_W'(vsq_reg) < alu_res;
                ST_T2: turn_reg <= sat_q16(alu_res);
                ST_C2: climb_reg <= sat_q16(alu_res);
                ST_P2: pd_reg   <= alu_res[57:16];
                ST_SQ:
                begin
                    root_reg <= alu_res[24:0];
                    if (pd_reg > 42'sd0)
                    begin
                        climb_reg <= 32'h7FFF_FFFF;
                    end
                    else if (pd_reg < 42'sd0)
                    begin
                        climb_reg <= 32'h8000_0000;
                    end
                    else
                    begin
                        climb_reg <= 32'h0000_0000;
                    end
                end
                ST_DV: s_reg     <= alu_res[NUM_W-1:0];
                ST_SM: climb_reg <= sat_q16(alu_res);
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        alu_cmd.start |-> !alu_stat.busy)
        else $error("arithmetic unit started while busy");

    a_done_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        alu_stat.done |-> (state_reg != ST_IDLE && state_reg != ST_OUT))
        else $error("arithmetic unit finished outside a compute step");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_MX))
        else $error("accepted transfer did not start the sequence");

    a_land_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && land_reg) |-> (dl_reg != '0 && vl_reg != '0))
        else $error("landing chosen with a zero limit");
`endif

endmodule

FILE: verif/layp_checker.sv
// ============================================================================
// layp_checker
// Watches the tick, command and register channels of the landing PD core,
// predicts each command from the tick and the register copy, and compares.
// ============================================================================
module layp_checker
    import layp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [351:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [71:0]  m_axis_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data,
    output int           fail_count,
    output int           pending_cmds
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] climb;
        logic [31:0] turn;
        logic        landing;
    } cmd_t;

    cmd_t cmd_q[$];
    longint unsigned kp_alt, kd_alt, kp_hdg, kd_hdg, dist_lim, vel_lim, cruise, tps;
    longint last_tx, last_ty, last_th;

    function automatic longint unsigned magnitude(input longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor_q16(input longint v);
        if (v >= 0) return v >>> 16;
        return -longint'((magnitude(v) + 65535) >> 16);
    endfunction

    function automatic longint unsigned square_clip(input longint v);
        longint unsigned u;
        u = magnitude(v);
        if (u > (64'd1 << 24)) u = 64'd1 << 24;
        return u * u;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint gained(input longint unsigned g, input longint x);
        longint unsigned ux, p;
        ux = magnitude(x);
        if (g != 0 && ux > (64'd1 << 61) / g) p = 64'd1 << 61;
        else p = g * ux;
        return x < 0 ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint scaled_product(input longint a, input longint b);
        longint unsigned ua, ub, p;
        logic neg;
        ua = magnitude(a);
        ub = magnitude(b);
        neg = (a < 0) != (b < 0);
        if (ua != 0 && ub > ((64'd1 << 48) - 1) / ua)
            return neg ? -64'sd2147483648 : 64'sd2147483647;
        p = ua * ub;
        if (neg) return clip32(-longint'((p + 65535) >> 16));
        return clip32(longint'(p >> 16));
    endfunction

    function automatic cmd_t control_tick(input logic [351:0] d);
        longint f[11];
        longint gvx, gvy, grate, dx, dy, climb, turn, pd, s;
        longint unsigned dsq, vsq, root_d;
        logic land;
        cmd_t r;
        for (int i = 0; i < 11; i++) f[i] = longint'($signed(d[32*i +: 32]));
        gvx = (f[0] - last_tx) * longint'(tps);
        gvy = (f[1] - last_ty) * longint'(tps);
        grate = (f[2] - last_th) * longint'(tps);
        dx = f[0] - f[3];
        dy = f[1] - f[4];
        dsq = square_clip(dx) + square_clip(dy);
        vsq = square_clip(gvx - f[7]) + square_clip(gvy - f[8]);
        land = dsq < dist_lim * dist_lim && vsq < vel_lim * vel_lim;
        if (land)
        begin
            root_d = root_floor(dsq);
            pd = floor_q16(-longint'(kp_alt) * f[5] - longint'(kd_alt) * f[9]);
            if (root_d == 0)
                climb = pd > 0 ? 64'sd2147483647 : (pd < 0 ? -64'sd2147483648 : 0);
            else
            begin
                s = longint'(((3 * dist_lim) << 16) / (10 * root_d));
                climb = scaled_product(s, pd);
            end
        end
        else
            climb = clip32(floor_q16(longint'(kp_alt) * (longint'(cruise) - f[5])
                                     - longint'(kd_alt) * f[9]));
        turn = clip32(floor_q16(gained(kp_hdg, f[2] - f[6]) + gained(kd_hdg, grate - f[10])));
        last_tx = f[0];
        last_ty = f[1];
        last_th = f[2];
        r.climb = climb[31:0];
        r.turn = turn[31:0];
        r.landing = land;
        return r;
    endfunction

    assign pending_cmds = cmd_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        cmd_t want, got;
        int errs;
        if (!rst_n)
        begin
            kp_alt = RST_KP_ALT; kd_alt = RST_KD_ALT;
            kp_hdg = RST_KP_HDG; kd_hdg = RST_KD_HDG;
            dist_lim = RST_DIST_LIM; vel_lim = RST_VEL_LIM;
            cruise = RST_CRUISE; tps = RST_TPS;
            last_tx = 0; last_ty = 0; last_th = 0;
            cmd_q.delete();
            fail_count <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_KP_ALT:   kp_alt = cfg_data;
                    CFG_KD_ALT:   kd_alt = cfg_data;
                    CFG_KP_HDG:   kp_hdg = cfg_data;
                    CFG_KD_HDG:   kd_hdg = cfg_data;
                    CFG_DIST_LIM: dist_lim = cfg_data;
                    CFG_VEL_LIM:  vel_lim = cfg_data;
                    CFG_CRUISE:   cruise = cfg_data;
                    CFG_TPS:      tps = cfg_data[9:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.climb = m_axis_tdata[31:0];
                got.turn = m_axis_tdata[63:32];
                got.landing = m_axis_tdata[64];
                if (cmd_q.size() == 0)
                begin
                    $display("%0t: unexpected command %h", $time, got);
                    errs = errs + 1;
                end
                else
                begin
                    want = cmd_q.pop_front();
                    if (got.climb !== want.climb)
                    begin
                        $display("%0t: climb_cmd expected %h actual %h", $time,
                                 want.climb, got.climb);
                        errs = errs + 1;
                    end
                    if (got.turn !== want.turn)
                    begin
                        $display("%0t: turn_cmd expected %h actual %h", $time,
                                 want.turn, got.turn);
                        errs = errs + 1;
                    end
                    if (got.landing !== want.landing)
                    begin
                        $display("%0t: landing expected %b actual %b", $time,
                                 want.landing, got.landing);
                        errs = errs + 1;
                    end
                end
            end
            if (errs != 0) fail_count <= fail_count + errs;
            if (s_axis_tvalid && s_axis_tready) cmd_q.push_back(control_tick(s_axis_tdata));
        end
    end

endmodule

FILE: verif/tb_top.sv
// ============================================================================
// tb_top
// Drives control ticks and register writes into the landing PD core with
// random gaps and stalls; the checker compares every command.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import layp_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [351:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [23:0]  cfg_data = '0;
    int           fail_count;
    int           pending_cmds;
    int           cycle_count = 0;
    int           hold_off = 0;
    logic         stall_mode = 1'b1;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    landing_altitude_yaw_pd_core u_top (.*);

    layp_checker u_chk (.*);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 600);
    endfunction

    // Receiver: random stalls, or always ready when stall mode is off, plus one long hold-off requested by the sender.
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!stall_mode) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 9) < 7);
    end

    function automatic logic [31:0] field_val(input int pos);
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return $urandom_range(0, 262143) - 131072;
        endcase
    endfunction

    // The valid line stays high between back-to-back transfers; drain lowers it.
    task automatic send_tick(input logic [351:0] d);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_axis_tdata <= d;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [23:0] v);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_cmds != 0) @(negedge clk);
        repeat (500) @(negedge clk);
    endtask

    // Near-landing tick: target close to the drone and moving slowly.
    function automatic logic [351:0] near_tick(input logic [351:0] last);
        logic [351:0] d;
        for (int i = 0; i < 11; i++) d[32*i +: 32] = $urandom_range(0, 131071) - 65536;
        d[31:0] = last[31:0] + $urandom_range(0, 255) - 128;
        d[63:32] = last[63:32] + $urandom_range(0, 255) - 128;
        d[127:96] = d[31:0] + ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 65535) - 32768);
        d[159:128] = d[63:32] + ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 65535) - 32768);
        d[255:224] = 0;
        d[287:256] = 0;
        if ($urandom_range(0, 9) == 0) d[191:160] = field_val(0);
        return d;
    endfunction

    task automatic random_regs(input int phase);
        logic [23:0] lo, hi;
        lo = (phase == 1) ? 24'd0 : 24'd1;
        hi = 24'hFF_FFFF;
        write_reg(CFG_KP_ALT, phase == 2 ? hi : $urandom_range(0, 300000));
        write_reg(CFG_KD_ALT, phase == 2 ? hi : (phase == 1 ? lo : $urandom_range(0, 100000)));
        write_reg(CFG_KP_HDG, phase == 2 ? hi : $urandom_range(0, 300000));
        write_reg(CFG_KD_HDG, phase == 2 ? hi : (phase == 1 ? lo : $urandom_range(0, 100000)));
        write_reg(CFG_DIST_LIM, phase == 2 ? hi : (phase == 1 ? lo : $urandom_range(0, 400000)));
        write_reg(CFG_VEL_LIM, phase == 2 ? hi : $urandom_range(0, 400000));
        write_reg(CFG_CRUISE, phase == 2 ? hi : (phase == 1 ? lo : $urandom));
        write_reg(CFG_TPS, phase == 2 ? 24'd1023 : (phase == 1 ? 24'd0 : $urandom_range(1, 1000)));
    endtask

    initial
    begin
        logic [351:0] d, prev;
        prev = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);

        // Directed: zero ticks (zero distance landing), extremes, all ones, alternating bits, near ticks.
        send_tick('0);
        d = '0;
        d[191:160] = 32'h0001_0000;
        send_tick(d);
        send_tick({11{32'h7FFF_FFFF}});
        send_tick({11{32'h8000_0000}});
        send_tick({11{32'hFFFF_FFFF}});
        send_tick({11{32'h5555_5555}});
        send_tick({11{32'hAAAA_AAAA}});
        for (int i = 0; i < 6; i++)
        begin
            prev = near_tick(prev);
            send_tick(prev);
        end

        // Long receiver hold-off while ticks keep coming.
        hold_off = 2500;
        for (int i = 0; i < 6; i++)
        begin
            prev = near_tick(prev);
            send_tick(prev);
        end
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase > 0) random_regs(phase == 5 ? 0 : phase);
            if (phase == 3) write_reg(CFG_TPS, 24'd1);
            if (phase == 4) write_reg(CFG_DIST_LIM, 24'd400000);
            stall_mode = (phase != 4);
            for (int i = 0; i < 150; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    d = '0;
                    for (int k = 0; k < 11; k++) d[32*k +: 32] = field_val(k);
                    send_tick(d);
                end
                else
                begin
                    prev = near_tick(prev);
                    send_tick(prev);
                end
            end
            drain();
        end

        if (fail_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
sv/layp_pkg.sv
sv/layp_alu.sv
sv/landing_altitude_yaw_pd_core.sv
verif/layp_checker.sv
verif/tb_top.sv
